/* hdl/cmap_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmap_pkg
// Shared types and constants of the color map entry generator.
// ----------------------------------------------------------------------------
package cmap_pkg;

  // Field widths of the ports
  localparam int IDX_W     = 12;
  localparam int SIZE_W    = 13;
  localparam int RGBA_W    = 32;
  localparam int CFG_IDX_W = 2;

  // Largest table that the index path supports
  localparam int MAX_ENTRIES = 4096;
  localparam int DIVISOR_W   = $clog2(MAX_ENTRIES);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd1;

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 13'd256;
  localparam logic [7:0]        ALPHA_OPAQUE   = 8'hFF;

  typedef enum logic {
    MAP_HISTOGRAM = 1'b0,
    MAP_WATERFALL = 1'b1
  } map_mode_t;

  // Hue sectors of the six-sector HSV conversion
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } hue_sector_t;

endpackage

/* hdl/colormap_entry_generator_unit.sv */
`timescale 1ns / 1ps
// Throughput: one request per cycle unless the spare result slot is occupied;
//   the restoring divider for the table position resolves one quotient bit per stage,
//   which sets the pipeline depth.
// A two-entry output buffer keeps in_ready high while one result waits downstream.
// Reset (rst_n low, synchronous): all valid bits clear, map_mode = histogram,
//   table_size = 256.
// ----------------------------------------------------------------------------
// colormap_entry_generator_unit
// Pipelined HSV ramp color map: table index in, packed RGBA word out.
// ----------------------------------------------------------------------------
module colormap_entry_generator_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cmap_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cmap_pkg::SIZE_W-1:0]           cfg_data,
  // requests
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [cmap_pkg::IDX_W-1:0]            in_entry_index,
  // results
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [cmap_pkg::RGBA_W-1:0]           out_packed_rgba
);

  localparam int F    = FRAC_BITS;
  localparam int W1   = F + 1;                     // values up to one
  localparam int W2   = F + 2;                     // values slightly above one
  localparam int D_W  = cmap_pkg::DIVISOR_W;
  localparam int DV_W = cmap_pkg::IDX_W + F + 1;   // dividend
  localparam int NDIV = F + 1;                     // one quotient bit per stage
  localparam int NST  = NDIV + 7;                  // input, divider, A..E, pack

  localparam longint ONE_L  = longint'(1) << F;
  localparam longint HALF_L = ONE_L / 2;

  localparam logic [W1-1:0] ONE   = W1'(ONE_L);
  localparam logic [W1-1:0] QC_90 = W1'((9 * ONE_L + 5) / 10);
  localparam logic [W1-1:0] QC_50 = W1'((1 * ONE_L + 1) / 2);
  localparam logic [W1-1:0] QC_15 = W1'((15 * ONE_L + 50) / 100);
  localparam logic [W1-1:0] QC_80 = W1'((8 * ONE_L + 5) / 10);
  localparam logic [W1-1:0] QC_85 = W1'((85 * ONE_L + 50) / 100);
  localparam logic [W1-1:0] QC_60 = W1'((6 * ONE_L + 5) / 10);
  localparam logic [W1-1:0] QC_40 = W1'((4 * ONE_L + 5) / 10);
  localparam logic [W1-1:0] QC_75 = W1'((75 * ONE_L + 50) / 100);
  localparam logic [W1-1:0] QC_95 = W1'((95 * ONE_L + 50) / 100);
  localparam logic [W1-1:0] QC_05 = W1'((5 * ONE_L + 50) / 100);

  // (a * b + 1/2) >> F
  function automatic logic [W2-1:0] qmul(input logic [W2-1:0] a, input logic [W1-1:0] b);
    logic [W2+W1-1:0] prod;
    prod = (W2+W1)'(a) * (W2+W1)'(b);
    prod = prod + (W2+W1)'(HALF_L);
    return W2'(prod >> F);
  endfunction

  // (x * 255 + 1/2) >> F, saturated to a byte
  function automatic logic [7:0] to_byte(input logic [W2-1:0] x);
    logic [W2+7:0] m;
    logic [9:0]    c;
    m = {x, 8'h00} - (W2+8)'(x);
    m = m + (W2+8)'(HALF_L);
    c = 10'(m >> F);
    return (c > 10'd255) ? 8'hFF : c[7:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cmap_pkg::map_mode_t          map_mode_r;
  logic [cmap_pkg::SIZE_W-1:0]  table_size_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_mode_r   <= cmap_pkg::MAP_HISTOGRAM;
      table_size_r <= cmap_pkg::TABLE_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cmap_pkg::CFG_MAP_MODE:   map_mode_r   <= cmap_pkg::map_mode_t'(cfg_data[0]);
        cmap_pkg::CFG_TABLE_SIZE: table_size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: whole pipeline advances unless the spare result slot
  // is occupied
  // --------------------------------------------------------------------------
  logic           en;
  logic           spare_valid_r;
  logic [NST-1:0] vld_r;

  assign en       = !spare_valid_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // --------------------------------------------------------------------------
  // Input stage (index 0) and divider stages (1..NDIV)
  // --------------------------------------------------------------------------
  logic [DV_W-1:0]        div_rem_r   [NDIV+1];
  logic [DV_W-1:0]        div_rem_nxt [NDIV+1];
  logic [W1-1:0]          div_q_r     [NDIV+1];
  logic [W1-1:0]          div_q_nxt   [NDIV+1];
  logic [D_W-1:0]         div_d_r     [NDIV+1];
  logic [D_W-1:0]         div_d_nxt   [NDIV+1];
  cmap_pkg::map_mode_t    div_mode_r  [NDIV+1];
  cmap_pkg::map_mode_t    div_mode_nxt[NDIV+1];
  logic                   div_early_r  [NDIV+1];
  logic                   div_early_nxt[NDIV+1];

  always_comb begin : div_comb
    logic [cmap_pkg::SIZE_W-1:0] n;
    logic [D_W-1:0]              dm1;
    logic [cmap_pkg::IDX_W-1:0]  idx;
    logic [DV_W-1:0]             dsh;
    logic                        ge;

    // clamp table size and index, form the rounded dividend
    if (table_size_r < cmap_pkg::SIZE_W'(2)) begin
      n = cmap_pkg::SIZE_W'(2);
    end else if (table_size_r > cmap_pkg::SIZE_W'(cmap_pkg::MAX_ENTRIES)) begin
      n = cmap_pkg::SIZE_W'(cmap_pkg::MAX_ENTRIES);
    end else begin
      n = table_size_r;
    end
    dm1 = D_W'(n - cmap_pkg::SIZE_W'(1));
    idx = (in_entry_index > cmap_pkg::IDX_W'(dm1)) ? cmap_pkg::IDX_W'(dm1) : in_entry_index;

    div_rem_nxt[0]   = {1'b0, idx, {F{1'b0}}} + DV_W'(dm1 >> 1);
    div_q_nxt[0]     = '0;
    div_d_nxt[0]     = dm1;
    div_mode_nxt[0]  = map_mode_r;
    div_early_nxt[0] = cmap_pkg::SIZE_W'(idx) < (n >> 4);

    for (int k = 1; k <= NDIV; k++) begin
      dsh = DV_W'(div_d_r[k-1]) << (NDIV - k);
      ge  = div_rem_r[k-1] >= dsh;
      div_rem_nxt[k]           = ge ? (div_rem_r[k-1] - dsh) : div_rem_r[k-1];
      div_q_nxt[k]             = div_q_r[k-1];
      div_q_nxt[k][NDIV - k]   = ge;
      div_d_nxt[k]             = div_d_r[k-1];
      div_mode_nxt[k]          = div_mode_r[k-1];
      div_early_nxt[k]         = div_early_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= NDIV; k++) begin
        div_rem_r[k]   <= div_rem_nxt[k];
        div_q_r[k]     <= div_q_nxt[k];
        div_d_r[k]     <= div_d_nxt[k];
        div_mode_r[k]  <= div_mode_nxt[k];
        div_early_r[k] <= div_early_nxt[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: position products
  // --------------------------------------------------------------------------
  logic [W1-1:0]       a_p_r,  a_p_nxt;
  logic [W1-1:0]       a_hp_r, a_hp_nxt;
  logic [W2-1:0]       a_vp_r, a_vp_nxt;
  cmap_pkg::map_mode_t a_mode_r;
  logic                a_early_r;

  always_comb begin
    a_p_nxt  = div_q_r[NDIV];
    a_hp_nxt = W1'(qmul(W2'(a_p_nxt),
                        (div_mode_r[NDIV] == cmap_pkg::MAP_WATERFALL) ? QC_75 : QC_80));
    a_vp_nxt = qmul(W2'(a_p_nxt), QC_95);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_p_r     <= a_p_nxt;
      a_hp_r    <= a_hp_nxt;
      a_vp_r    <= a_vp_nxt;
      a_mode_r  <= div_mode_r[NDIV];
      a_early_r <= div_early_r[NDIV];
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: hue, saturation, value of the selected map
  // --------------------------------------------------------------------------
  logic [W1-1:0] b_h_r, b_h_nxt;
  logic [W1-1:0] b_s_r, b_s_nxt;
  logic [W2-1:0] b_v_r, b_v_nxt;

  always_comb begin : hsv_comb
    logic [W1+1:0] p4;
    logic [W1-1:0] pd;
    logic [W1+1:0] dd;

    p4 = {a_p_r, 2'b00};
    pd = a_p_r - QC_85;
    dd = {1'b0, pd, 1'b0} + (W1+2)'(pd);

    if (a_mode_r == cmap_pkg::MAP_WATERFALL) begin
      b_h_nxt = (QC_75 > a_hp_r) ? (QC_75 - a_hp_r) : '0;
      b_s_nxt = ONE;
      b_v_nxt = a_vp_r + W2'(QC_05);
    end else if (a_early_r) begin
      b_h_nxt = QC_90;
      b_s_nxt = QC_50;
      b_v_nxt = W2'(QC_15) + p4[W2-1:0];
    end else begin
      b_h_nxt = QC_80 - a_hp_r;
      if (a_p_r < QC_85) begin
        b_s_nxt = ONE;
      end else if (dd >= (W1+2)'(ONE)) begin
        b_s_nxt = '0;
      end else begin
        b_s_nxt = ONE - dd[W1-1:0];
      end
      b_v_nxt = W2'(QC_60) + W2'((a_p_r < QC_40) ? a_p_r : QC_40);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_h_r <= b_h_nxt;
      b_s_r <= b_s_nxt;
      b_v_r <= b_v_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: sector and fraction of five times hue
  // --------------------------------------------------------------------------
  logic [2:0]    c_sec_r, c_sec_nxt;
  logic [F-1:0]  c_f_r,   c_f_nxt;
  logic [W1-1:0] c_omf_r, c_omf_nxt;
  logic [W1-1:0] c_oms_r, c_oms_nxt;
  logic [W1-1:0] c_s_r;
  logic [W2-1:0] c_v_r;
  logic          c_grey_r, c_grey_nxt;

  always_comb begin : sector_comb
    logic [W1+2:0] h5;
    h5         = {b_h_r, 2'b00} + (W1+3)'(b_h_r);
    c_sec_nxt  = h5[F+2:F];
    c_f_nxt    = h5[F-1:0];
    c_omf_nxt  = ONE - {1'b0, c_f_nxt};
    c_oms_nxt  = ONE - b_s_r;
    c_grey_nxt = (b_s_r == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sec_r  <= c_sec_nxt;
      c_f_r    <= c_f_nxt;
      c_omf_r  <= c_omf_nxt;
      c_oms_r  <= c_oms_nxt;
      c_s_r    <= b_s_r;
      c_v_r    <= b_v_r;
      c_grey_r <= c_grey_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: p', s*f, s*(1-f)
  // --------------------------------------------------------------------------
  logic [W2-1:0] d_pp_r, d_sf_r, d_sg_r;
  logic [W2-1:0] d_pp_nxt, d_sf_nxt, d_sg_nxt;
  logic [W2-1:0] d_v_r;
  logic [2:0]    d_sec_r;
  logic          d_grey_r;

  always_comb begin
    d_pp_nxt = qmul(c_v_r, c_oms_r);
    d_sf_nxt = qmul(W2'(c_s_r), {1'b0, c_f_r});
    d_sg_nxt = qmul(W2'(c_s_r), c_omf_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_pp_r   <= d_pp_nxt;
      d_sf_r   <= d_sf_nxt;
      d_sg_r   <= d_sg_nxt;
      d_v_r    <= c_v_r;
      d_sec_r  <= c_sec_r;
      d_grey_r <= c_grey_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: q and t
  // --------------------------------------------------------------------------
  logic [W2-1:0] e_q_r, e_t_r, e_q_nxt, e_t_nxt;
  logic [W2-1:0] e_pp_r, e_v_r;
  logic [2:0]    e_sec_r;
  logic          e_grey_r;

  always_comb begin : qt_comb
    logic [W1-1:0] sfc;
    logic [W1-1:0] sgc;
    sfc     = (d_sf_r > W2'(ONE)) ? ONE : d_sf_r[W1-1:0];
    sgc     = (d_sg_r > W2'(ONE)) ? ONE : d_sg_r[W1-1:0];
    e_q_nxt = qmul(d_v_r, ONE - sfc);
    e_t_nxt = qmul(d_v_r, ONE - sgc);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_q_r    <= e_q_nxt;
      e_t_r    <= e_t_nxt;
      e_pp_r   <= d_pp_r;
      e_v_r    <= d_v_r;
      e_sec_r  <= d_sec_r;
      e_grey_r <= d_grey_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage G: sector select, byte rounding, packing
  // --------------------------------------------------------------------------
  logic [cmap_pkg::RGBA_W-1:0] g_rgba_r, g_rgba_nxt;

  always_comb begin : pack_comb
    logic [W2-1:0] r, g, b;
    case (cmap_pkg::hue_sector_t'(e_sec_r))
      cmap_pkg::SEC_RED_YEL: begin r = e_v_r;  g = e_t_r;  b = e_pp_r; end
      cmap_pkg::SEC_YEL_GRN: begin r = e_q_r;  g = e_v_r;  b = e_pp_r; end
      cmap_pkg::SEC_GRN_CYN: begin r = e_pp_r; g = e_v_r;  b = e_t_r;  end
      cmap_pkg::SEC_CYN_BLU: begin r = e_pp_r; g = e_q_r;  b = e_v_r;  end
      cmap_pkg::SEC_BLU_MAG: begin r = e_t_r;  g = e_pp_r; b = e_v_r;  end
      default:               begin r = e_v_r;  g = e_pp_r; b = e_q_r;  end
    endcase
    // zero saturation: grey
    if (e_grey_r) begin
      r = e_v_r;
      g = e_v_r;
      b = e_v_r;
    end
    g_rgba_nxt = {cmap_pkg::ALPHA_OPAQUE, to_byte(b), to_byte(g), to_byte(r)};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_rgba_r <= g_rgba_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output buffer: main register plus one spare slot
  // --------------------------------------------------------------------------
  logic                        out_valid_r;
  logic [cmap_pkg::RGBA_W-1:0] out_rgba_r;
  logic [cmap_pkg::RGBA_W-1:0] spare_rgba_r;
  logic                        push;

  assign push = en && vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      spare_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (spare_valid_r) begin
        out_valid_r   <= 1'b1;
        spare_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      // main slot held downstream: park the new result
      spare_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (spare_valid_r) begin
        out_rgba_r <= spare_rgba_r;
      end else if (push) begin
        out_rgba_r <= g_rgba_r;
      end
    end else if (push) begin
      spare_rgba_r <= g_rgba_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_packed_rgba = out_rgba_r;

`ifndef SYNTHESIS
  a_spare_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    spare_valid_r |-> out_valid_r)
    else $error("spare result slot occupied while main slot is empty");

  a_park_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && push) |=> spare_valid_r)
    else $error("result leaving the pipeline during a stall was not parked");

  a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NDIV] |-> (div_rem_r[NDIV] < DV_W'(div_d_r[NDIV])))
    else $error("divider remainder not below divisor at last stage");
`endif

endmodule

/* dv/colormap_entry_generator_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colormap_entry_generator_checker
// Watches the request, result and register channels of the color map entry
// generator, computes the RGBA word each request must produce from a shadow
// copy of the registers, and compares the results in order.
// ----------------------------------------------------------------------------
module colormap_entry_generator_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [cmap_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cmap_pkg::SIZE_W-1:0]    cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [cmap_pkg::IDX_W-1:0]     in_entry_index,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [cmap_pkg::RGBA_W-1:0]    out_packed_rgba,
  output int                             mismatches,
  output int                             outstanding,
  output int                             results_seen
);

  localparam logic [63:0] UNITY = 64'd1 << FRAC_BITS;

  cmap_pkg::map_mode_t         mode_q;
  logic [cmap_pkg::SIZE_W-1:0] size_q;
  logic [cmap_pkg::RGBA_W-1:0] rgba_expected [$];
  logic [cmap_pkg::RGBA_W-1:0] want;

  function automatic logic [63:0] fx_const(int unsigned num, int unsigned den);
    return (64'(num) * UNITY + 64'(den / 2)) / 64'(den);
  endfunction

  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
    return (a * b + (UNITY >> 1)) >> FRAC_BITS;
  endfunction

  function automatic logic [7:0] fx_to_byte(logic [63:0] x);
    logic [63:0] c;
    c = (x * 64'd255 + (UNITY >> 1)) >> FRAC_BITS;
    return (c > 64'd255) ? 8'hFF : c[7:0];
  endfunction

  function automatic logic [cmap_pkg::RGBA_W-1:0] predict_rgba(
    logic [cmap_pkg::IDX_W-1:0] entry, cmap_pkg::map_mode_t mode,
    logic [cmap_pkg::SIZE_W-1:0] size_reg);
    logic [63:0] n, idx, pos, hue, sat, val, hp, dev;
    logic [63:0] h5, frac, pp, sf, sg, qv, tv, r, g, b;
    cmap_pkg::hue_sector_t sector;
    n = 64'(size_reg);
    if (n < 64'd2) n = 64'd2;
    else if (n > 64'(cmap_pkg::MAX_ENTRIES)) n = 64'(cmap_pkg::MAX_ENTRIES);
    idx = 64'(entry);
    if (idx > n - 64'd1) idx = n - 64'd1;
    pos = ((idx << FRAC_BITS) + (n - 64'd1) / 64'd2) / (n - 64'd1);

    if (mode == cmap_pkg::MAP_HISTOGRAM) begin
      // the lowest sixteenth of the table gets a fixed dim magenta ramp
      if (idx < (n >> 4)) begin
        hue = fx_const(9, 10);
        sat = fx_const(1, 2);
        val = fx_const(15, 100) + 64'd4 * pos;
      end else begin
        hue = fx_const(8, 10) - fx_mul(pos, fx_const(8, 10));
        if (pos < fx_const(85, 100)) begin
          sat = UNITY;
        end else begin
          dev = 64'd3 * (pos - fx_const(85, 100));
          sat = (dev >= UNITY) ? 64'd0 : UNITY - dev;
        end
        val = fx_const(6, 10) + ((pos < fx_const(4, 10)) ? pos : fx_const(4, 10));
      end
    end else begin
      hp  = fx_mul(pos, fx_const(75, 100));
      hue = (fx_const(75, 100) > hp) ? fx_const(75, 100) - hp : 64'd0;
      sat = UNITY;
      val = fx_mul(pos, fx_const(95, 100)) + fx_const(5, 100);
    end

    if (sat > UNITY) sat = UNITY;
    if (sat == 64'd0) begin
      r = val;
      g = val;
      b = val;
    end else begin
      h5     = hue * 64'd5;
      sector = cmap_pkg::hue_sector_t'(3'((h5 >> FRAC_BITS) % 64'd6));
      frac   = h5 & (UNITY - 64'd1);
      pp     = fx_mul(val, UNITY - sat);
      sf     = fx_mul(sat, frac);
      sg     = fx_mul(sat, UNITY - frac);
      qv     = fx_mul(val, UNITY - ((sf > UNITY) ? UNITY : sf));
      tv     = fx_mul(val, UNITY - ((sg > UNITY) ? UNITY : sg));
      case (sector)
        cmap_pkg::SEC_RED_YEL: begin r = val; g = tv;  b = pp;  end
        cmap_pkg::SEC_YEL_GRN: begin r = qv;  g = val; b = pp;  end
        cmap_pkg::SEC_GRN_CYN: begin r = pp;  g = val; b = tv;  end
        cmap_pkg::SEC_CYN_BLU: begin r = pp;  g = qv;  b = val; end
        cmap_pkg::SEC_BLU_MAG: begin r = tv;  g = pp;  b = val; end
        default: begin r = val; g = pp; b = qv; end
      endcase
    end
    return {cmap_pkg::ALPHA_OPAQUE, fx_to_byte(b), fx_to_byte(g), fx_to_byte(r)};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q <= cmap_pkg::MAP_HISTOGRAM;
      size_q <= cmap_pkg::TABLE_SIZE_RST;
      rgba_expected.delete();
      outstanding  <= 0;
      mismatches   <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cmap_pkg::CFG_MAP_MODE:   mode_q <= cmap_pkg::map_mode_t'(cfg_data[0]);
          cmap_pkg::CFG_TABLE_SIZE: size_q <= cfg_data;
          default: ;
        endcase
      end
      // retire before queuing, so a result never matches a request of the same edge
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (rgba_expected.size() == 0) begin
          $error("packed_rgba: no request waiting, expected none, actual %08h",
                 out_packed_rgba);
          mismatches <= mismatches + 1;
        end else begin
          want = rgba_expected.pop_front();
          if (want !== out_packed_rgba) begin
            $error("packed_rgba: expected %08h, actual %08h", want, out_packed_rgba);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && in_ready)
        rgba_expected.push_back(predict_rgba(in_entry_index, mode_q, size_q));
      outstanding <= rgba_expected.size();
    end
  end

endmodule

/* dv/colormap_entry_generator_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colormap_entry_generator_unit_tb
// Drives table indexes through the color map entry generator under both map
// modes and a sweep of table sizes, with random gaps and stalls on both sides;
// the checker beside the block compares every RGBA word.
// ----------------------------------------------------------------------------
module colormap_entry_generator_unit_tb;

  localparam int FRAC_BITS         = 16;
  localparam int CYCLE_LIMIT       = 600000;
  localparam int DRAIN_CYCLES      = FRAC_BITS + 16;
  localparam int HOLD_OFF_CYCLES   = 300;
  localparam int HOLD_OFF_PHASE    = 4;
  localparam int RANDOM_PHASES     = 16;
  localparam int SWEEP_PHASES      = 12;
  localparam int ENTRIES_PER_PHASE = 66;
  localparam logic [cmap_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [cmap_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cmap_pkg::SIZE_W-1:0]    cfg_data;
  logic                           in_valid;
  logic                           in_ready;
  logic [cmap_pkg::IDX_W-1:0]     in_entry_index;
  logic                           out_valid;
  logic                           out_ready;
  logic [cmap_pkg::RGBA_W-1:0]    out_packed_rgba;

  int mismatches;
  int outstanding;
  int results_seen;
  int requests_sent = 0;
  int hold_off_req  = 0;
  bit tx_gaps       = 1'b0;

  int unsigned hist_probe [13] = '{0, 1, 15, 16, 17, 102, 103, 217, 218, 254, 255, 256, 4095};
  int unsigned fall_probe [5]  = '{0, 64, 128, 255, 4095};
  int unsigned size_sweep [SWEEP_PHASES] =
    '{0, 1, 2, 3, 16, 17, 4095, 4096, 8191, 8190, 1000, 256};

  colormap_entry_generator_unit #(.FRAC_BITS(FRAC_BITS)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_entry_index (in_entry_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_packed_rgba(out_packed_rgba)
  );

  colormap_entry_generator_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_entry_index (in_entry_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_packed_rgba(out_packed_rgba),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .results_seen   (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_entry(input logic [cmap_pkg::IDX_W-1:0] idx);
    in_valid       <= 1'b1;
    in_entry_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [cmap_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cmap_pkg::SIZE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold requests until every result is back; the outstanding count is registered
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : receiver
    int stall_left;
    int calm_left;
    int hold_off_seen;
    bit calm;
    stall_left    = 0;
    calm_left     = 0;
    hold_off_seen = 0;
    calm          = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_seen != hold_off_req) begin
        hold_off_seen = hold_off_req;
        stall_left    = HOLD_OFF_CYCLES;
      end
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(50, 200);
      end
      calm_left--;
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) stall_left = gap_len();
      end
      @(posedge clk);
    end
  end

  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $error("run exceeded %0d cycles with %0d results outstanding", CYCLE_LIMIT, outstanding);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int                          phase;
    int                          k;
    int                          eff_n;
    int                          low_n;
    logic [cmap_pkg::SIZE_W-1:0] size_sel;
    logic [cmap_pkg::SIZE_W-1:0] mode_word;
    cmap_pkg::map_mode_t         mode_sel;
    logic [cmap_pkg::IDX_W-1:0]  pick;

    rst_n          <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= cmap_pkg::CFG_MAP_MODE;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    in_entry_index <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: fixed-hue band edge, 0.4 and 0.85 knees, clamped indexes
    foreach (hist_probe[slot]) send_entry(cmap_pkg::IDX_W'(hist_probe[slot]));
    wait_idle();
    write_reg(cmap_pkg::CFG_MAP_MODE, cmap_pkg::SIZE_W'(cmap_pkg::MAP_WATERFALL));
    foreach (fall_probe[slot]) send_entry(cmap_pkg::IDX_W'(fall_probe[slot]));
    wait_idle();
    // writes to an unmapped index must leave both registers alone
    write_reg(CFG_UNMAPPED, '1);
    send_entry(cmap_pkg::IDX_W'(0));
    send_entry(cmap_pkg::IDX_W'(200));
    wait_idle();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < SWEEP_PHASES) begin
        size_sel = cmap_pkg::SIZE_W'(size_sweep[phase]);
        mode_sel = cmap_pkg::map_mode_t'(phase[0]);
      end else begin
        size_sel = (phase[0]) ? cmap_pkg::SIZE_W'($urandom_range(0, 8191))
                              : cmap_pkg::SIZE_W'($urandom_range(2, cmap_pkg::MAX_ENTRIES));
        mode_sel = cmap_pkg::map_mode_t'($urandom_range(0, 1));
      end
      mode_word    = cmap_pkg::SIZE_W'($urandom);
      mode_word[0] = mode_sel;
      write_reg(cmap_pkg::CFG_TABLE_SIZE, size_sel);
      write_reg(cmap_pkg::CFG_MAP_MODE, mode_word);

      eff_n = int'(size_sel);
      if (eff_n < 2) eff_n = 2;
      else if (eff_n > cmap_pkg::MAX_ENTRIES) eff_n = cmap_pkg::MAX_ENTRIES;
      low_n = eff_n >> 4;

      tx_gaps = ($urandom_range(0, 3) != 0);
      if (phase == HOLD_OFF_PHASE) begin
        // keep offering back to back while the output is held off
        tx_gaps = 1'b0;
        hold_off_req <= hold_off_req + 1;
      end

      for (k = 0; k < ENTRIES_PER_PHASE; k++) begin
        case ($urandom_range(0, 9))
          0: pick = cmap_pkg::IDX_W'($urandom_range(0, 4095));
          1: begin
            case ($urandom_range(0, 3))
              0:       pick = '0;
              1:       pick = cmap_pkg::IDX_W'(eff_n - 1);
              2:       pick = cmap_pkg::IDX_W'(low_n);
              default: pick = cmap_pkg::IDX_W'((low_n == 0) ? 0 : low_n - 1);
            endcase
          end
          default: pick = cmap_pkg::IDX_W'($urandom_range(0, eff_n - 1));
        endcase
        send_entry(pick);
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests and %0d checked results over %0d register settings.",
             requests_sent, results_seen, RANDOM_PHASES + 3);
    $display("Both map modes, table sizes 0 to 8191, clamped indexes, gaps and a long hold-off.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
